// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define FDF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/fdf_pkg.sv
// ---------------------------------------------------------------------------
// Despeckle filter package
// Payload types, register indexes and constants of the despeckle filter.
// ---------------------------------------------------------------------------
`default_nettype none

package fdf_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int LEVEL_W = 4;
  localparam int GLYPH_W = 7;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd9;

  localparam logic [CFG_W-1:0] CFG_RESET_COLS = 11'd64;
  localparam logic [CFG_W-1:0] CFG_RESET_ROWS = 11'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 4'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Output buffer between the filter stage and the result channel.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic               op;
    logic [LEVEL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] out_level;
    logic [GLYPH_W-1:0] glyph;
    logic               row_end;
    logic               frame_end;
  } out_item_t;

  // Character shown for each gray level.
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    case (lvl)
      4'd0:    g = 7'h20;  // space
      4'd1:    g = 7'h2E;  // .
      4'd2:    g = 7'h60;  // `
      4'd3:    g = 7'h3A;  // :
      4'd4:    g = 7'h7E;  // ~
      4'd5:    g = 7'h2A;  // *
      4'd6:    g = 7'h3D;  // =
      4'd7:    g = 7'h21;  // !
      4'd8:    g = 7'h25;  // %
      default: g = 7'h23;  // #
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fdf_out_fifo.sv
// ---------------------------------------------------------------------------
// Despeckle filter output buffer
// Small register FIFO that decouples the filter stage from the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fdf_out_fifo import fdf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  out_item_t             push_item_i,
  output logic [FIFO_CNT_W-1:0] count_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  localparam int PtrW = $clog2(FIFO_DEPTH);

  out_item_t             buf_q [FIFO_DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = buf_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_item_i;
    end
  end

  `FDF_NEVER(a_push_full, push_i && !pop && count_q == FIFO_CNT_W'(FIFO_DEPTH), "push into full output buffer")
  `FDF_NEVER(a_cnt_range, count_q > FIFO_CNT_W'(FIFO_DEPTH), "output buffer count out of range")
  `FDF_ASSERT(a_cnt_up, push_i && !pop |=> count_q == $past(count_q) + 1'b1, "count did not advance on push")

endmodule

`default_nettype wire

// File: rtl/four_neighbor_despeckle_filter.sv
// ---------------------------------------------------------------------------
// Four-neighbour despeckle filter
// Raster impulse-noise removal over two line stores with a filter stage and a
// small output buffer.
// ---------------------------------------------------------------------------
//  Channel  | Signals                      | Payload
//  ---------+------------------------------+---------------------------------
//  input    | in_valid_i / in_ready_o      | in_item_i  (op, level)
//  result   | out_valid_o / out_ready_i    | out_item_o (level, glyph, ends)
//  config   | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  One item per clock while the input is not stalled. A pixel is read from the
//  middle and upper line stores on acceptance and filtered in the next cycle;
//  the filter stage then pushes the result into the output buffer. Results
//  trail their pixels by frame_cols items; flush items drain them. Reset needs
//  no clearing pass. Input stalls only while the three-entry output buffer
//  plus the filter stage hold three results.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module four_neighbor_despeckle_filter import fdf_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int ColW  = $clog2(MAX_COLS);
  localparam int CntW  = $clog2(MAX_COLS + 1);
  localparam int RowW  = $clog2(MAX_ROWS);
  localparam int RcntW = $clog2(MAX_ROWS + 1);

  typedef struct packed {
    logic use_left;
    logic use_up;
    logic use_right;
    logic use_down;
    logic last_col;
    logic last_row;
  } nb_sel_t;

  // Configuration and position state
  logic [CFG_W-1:0] cols_q, rows_q;
  logic [CntW-1:0]  cols_eff;
  logic [RcntW-1:0] rows_eff;
  logic [ColW-1:0]  in_col_q, in_col_d, emit_col_q, emit_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, emit_row_q, emit_row_d;
  logic [CntW-1:0]  pend_q, pend_d;

  logic               cfg_acc, in_acc, is_pix, emit, restart;
  logic [LEVEL_W-1:0] lvl_sat;
  nb_sel_t            sel;
  logic [ColW-1:0]    mid_ra, mid_rb;

  // Line stores and their read registers
  logic [LEVEL_W-1:0] mid_mem_q [MAX_COLS];
  logic [LEVEL_W-1:0] up_mem_q  [MAX_COLS];
  logic [LEVEL_W-1:0] mid_rd_a_q, mid_rd_b_q, up_rd_q;
  logic               up_we;

  // Filter stage
  logic               s1_valid_q, s1_pix_q, s1_emit_q;
  logic [ColW-1:0]    s1_wcol_q;
  nb_sel_t            s1_sel_q;
  logic [LEVEL_W-1:0] s1_down_q, last_center_q;

  logic [LEVEL_W-1:0] nb [4];
  logic [3:0]         nb_en;
  logic [5:0]         nb_sum, avg, res;
  logic [2:0]         nb_cnt;
  logic               near;
  logic [12:0]        third_prod;
  logic [LEVEL_W-1:0] cur;
  out_item_t          push_item;
  logic               push;

  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   credit;

  // -------------------------------------------------------------------------
  // Handshakes and clamped frame size
  // -------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_pix      = (in_item_i.op == OP_PIXEL);

  assign credit     = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_valid_q && s1_emit_q);
  assign in_ready_o = (credit < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

  always_comb begin
    if (cols_q < CFG_W'(2)) begin
      cols_eff = CntW'(2);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_eff = CntW'(MAX_COLS);
    end else begin
      cols_eff = CntW'(cols_q);
    end
    if (rows_q < CFG_W'(2)) begin
      rows_eff = RcntW'(2);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = RcntW'(MAX_ROWS);
    end else begin
      rows_eff = RcntW'(rows_q);
    end
  end

  assign lvl_sat = (in_item_i.level > LEVEL_MAX) ? LEVEL_MAX : in_item_i.level;

  // -------------------------------------------------------------------------
  // Position bookkeeping and neighbour selection
  // -------------------------------------------------------------------------
  always_comb begin
    sel.last_col = (CntW'(emit_col_q) >= cols_eff - CntW'(1));
    sel.last_row = (RcntW'(emit_row_q) >= rows_eff - RcntW'(1));
    sel.use_left = (emit_col_q != '0);
    sel.use_up   = (emit_row_q != '0);
    if (is_pix) begin
      emit          = (pend_q >= cols_eff);
      sel.use_right = !sel.last_col;
      sel.use_down  = !sel.last_row;
    end else begin
      emit          = (pend_q != '0);
      sel.use_right = !sel.last_col && (pend_q >= CntW'(2));
      sel.use_down  = 1'b0;
    end

    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    emit_col_d = emit_col_q;
    emit_row_d = emit_row_q;
    pend_d     = pend_q;
    if (in_acc) begin
      if (is_pix) begin
        if (CntW'(in_col_q) + CntW'(1) >= cols_eff) begin
          in_col_d = '0;
          in_row_d = (RcntW'(in_row_q) + RcntW'(1) >= rows_eff) ? '0 : in_row_q + RowW'(1);
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
        if (!emit) begin
          pend_d = pend_q + CntW'(1);
        end
      end else if (emit) begin
        pend_d = pend_q - CntW'(1);
      end
      if (emit) begin
        if (sel.last_col) begin
          emit_col_d = '0;
          emit_row_d = sel.last_row ? '0 : emit_row_q + RowW'(1);
        end else begin
          emit_col_d = emit_col_q + ColW'(1);
        end
      end
    end
  end

  assign restart = cfg_acc && ((cfg_index_i == CFG_FRAME_COLS) ||
                               (cfg_index_i == CFG_FRAME_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= CFG_RESET_COLS;
      rows_q     <= CFG_RESET_ROWS;
      in_col_q   <= '0;
      in_row_q   <= '0;
      emit_col_q <= '0;
      emit_row_q <= '0;
      pend_q     <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_FRAME_COLS: cols_q <= cfg_data_i;
          CFG_FRAME_ROWS: rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (restart) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        emit_col_q <= '0;
        emit_row_q <= '0;
        pend_q     <= '0;
      end else begin
        in_col_q   <= in_col_d;
        in_row_q   <= in_row_d;
        emit_col_q <= emit_col_d;
        emit_row_q <= emit_row_d;
        pend_q     <= pend_d;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Line stores: the middle store holds the newest pixel of each column, the
  // upper store the one a row before it. Port A reads the old middle entry
  // (centre, or the value that moves up), port B the right neighbour.
  // -------------------------------------------------------------------------
  assign mid_ra = is_pix ? in_col_q : emit_col_q;
  assign mid_rb = emit_col_q + ColW'(1);
  assign up_we  = s1_valid_q && s1_pix_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mid_rd_a_q <= mid_mem_q[mid_ra];
      mid_rd_b_q <= mid_mem_q[mid_rb];
      if (is_pix) begin
        mid_mem_q[in_col_q] <= lvl_sat;
      end
    end
  end

  // The move into the upper store is written from the filter stage registers and can miss a read; forward it.
  always_ff @(posedge clk_i) begin
    if (up_we) begin
      up_mem_q[s1_wcol_q] <= mid_rd_a_q;
    end
    if (in_acc) begin
      up_rd_q <= (up_we && (s1_wcol_q == emit_col_q)) ? mid_rd_a_q : up_mem_q[emit_col_q];
    end
  end

  // -------------------------------------------------------------------------
  // Filter stage
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pix_q   <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s1_pix_q   <= is_pix;
      s1_emit_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_wcol_q <= in_col_q;
      s1_sel_q  <= sel;
      s1_down_q <= lvl_sat;
    end
    if (s1_valid_q && s1_emit_q) begin
      last_center_q <= mid_rd_a_q;
    end
  end

  always_comb begin
    cur      = mid_rd_a_q;
    nb[0]    = last_center_q;
    nb[1]    = up_rd_q;
    nb[2]    = mid_rd_b_q;
    nb[3]    = s1_down_q;
    nb_en    = {s1_sel_q.use_down, s1_sel_q.use_right, s1_sel_q.use_up, s1_sel_q.use_left};
    nb_sum   = '0;
    nb_cnt   = '0;
    near     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (nb_en[i]) begin
        nb_sum = nb_sum + 6'(nb[i]);
        nb_cnt = nb_cnt + 3'd1;
        if (((nb[i] > cur) ? (nb[i] - cur) : (cur - nb[i])) <= LEVEL_W'(1)) begin
          near = 1'b1;
        end
      end
    end

    // Rounded mean; for three neighbours (2*sum+3)/6 is taken as a multiply by 43/256.
    third_prod = 13'(({nb_sum, 1'b0} + 7'd3)) * 13'd43;
    case (nb_cnt)
      3'd1:    avg = nb_sum;
      3'd2:    avg = (nb_sum + 6'd1) >> 1;
      3'd3:    avg = 6'(third_prod >> 8);
      3'd4:    avg = (nb_sum + 6'd2) >> 2;
      default: avg = 6'(cur);
    endcase

    res = ((nb_cnt != '0) && !near) ? avg : 6'(cur);
    if (res > 6'(LEVEL_MAX)) begin
      res = 6'(LEVEL_MAX);
    end

    push_item.out_level = res[LEVEL_W-1:0];
    push_item.glyph     = glyph_of(res[LEVEL_W-1:0]);
    push_item.row_end   = s1_sel_q.last_col;
    push_item.frame_end = s1_sel_q.last_col && s1_sel_q.last_row;
  end

  assign push = s1_valid_q && s1_emit_q;

  fdf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .count_o     (fifo_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `FDF_NEVER(a_pend_bound, pend_q > cols_eff, "pending count above row length")
  `FDF_NEVER(a_col_bound, CntW'(emit_col_q) >= cols_eff || CntW'(in_col_q) >= cols_eff, "column counter beyond row")
  `FDF_ASSERT(a_down_pixel, s1_valid_q && s1_emit_q && s1_sel_q.use_down |-> s1_pix_q, "lower neighbour used on flush")
  `FDF_ASSERT(a_level_range, out_valid_o |-> out_item_o.out_level <= LEVEL_MAX, "result level above nine")

endmodule

`default_nettype wire

// File: tb/tb_four_neighbor_despeckle_filter.sv
// ---------------------------------------------------------------------------
// Despeckle filter testbench
// Streams raster pixels and flush items through the four-neighbour despeckle
// filter under random idling on both channels, predicts every emitted pixel
// from a software copy of the pixel history and checks each result field.
// Frame sizes are reprogrammed between phases, small sizes and the clamped
// extremes among them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_four_neighbor_despeckle_filter;
  import fdf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HIST_DEPTH    = 2 * DEF_MAX_COLS + 2;
  localparam int unsigned SMALL_BUDGET  = 440;

  localparam logic [GLYPH_W-1:0] LEVEL_GLYPH [10] = '{
    7'h20, 7'h2E, 7'h60, 7'h3A, 7'h7E, 7'h2A, 7'h3D, 7'h21, 7'h25, 7'h23
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  four_neighbor_despeckle_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter model state
  logic [CFG_W-1:0]   cols_reg = CFG_RESET_COLS;
  logic [CFG_W-1:0]   rows_reg = CFG_RESET_ROWS;
  logic [LEVEL_W-1:0] seen_pixels[$];
  int unsigned        waiting_cnt;
  int unsigned        emit_col;
  int unsigned        emit_row;

  out_item_t   expected_pixels[$];
  in_item_t    queued_items[$];
  bit          tx_holding;
  int unsigned tx_gap;
  bit          tx_steady;
  int unsigned rx_hold;
  bit          rx_steady;
  bit          long_hold_done;
  int unsigned results_seen;
  int unsigned mismatches;

  function automatic int unsigned dim_used(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned past_pixel(input int unsigned d);
    return 32'(seen_pixels[seen_pixels.size() - 1 - d]);
  endfunction

  function automatic void restart_stream();
    seen_pixels.delete();
    waiting_cnt = 0;
    emit_col    = 0;
    emit_row    = 0;
  endfunction

  // Filter the oldest waiting pixel against its original neighbours.
  function automatic void emit_oldest_pixel();
    int unsigned cols, rows, d, v, n, sum, diff;
    int unsigned nbv[4];
    bit          far, last_col, last_row;
    out_item_t   res;
    cols     = dim_used(cols_reg, DEF_MAX_COLS);
    rows     = dim_used(rows_reg, DEF_MAX_ROWS);
    d        = waiting_cnt - 1;
    v        = past_pixel(d);
    last_col = (emit_col >= cols - 1);
    last_row = (emit_row >= rows - 1);
    n        = 0;
    sum      = 0;
    far      = 1'b1;
    if (emit_col > 0) begin
      nbv[n] = past_pixel(d + 1);
      n++;
    end
    if (emit_row > 0) begin
      nbv[n] = past_pixel(d + cols);
      n++;
    end
    // neighbours not yet received count as absent
    if (!last_col && d >= 1) begin
      nbv[n] = past_pixel(d - 1);
      n++;
    end
    if (!last_row && d >= cols) begin
      nbv[n] = past_pixel(d - cols);
      n++;
    end
    for (int unsigned i = 0; i < n; i++) begin
      diff = (nbv[i] > v) ? nbv[i] - v : v - nbv[i];
      if (diff <= 1) far = 1'b0;
      sum += nbv[i];
    end
    if (n != 0 && far) v = (2 * sum + n) / (2 * n);
    res.out_level = v[LEVEL_W-1:0];
    res.glyph     = LEVEL_GLYPH[v];
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    expected_pixels.push_back(res);
    waiting_cnt--;
    if (last_col) begin
      emit_col = 0;
      emit_row = last_row ? 0 : emit_row + 1;
    end else begin
      emit_col++;
    end
  endfunction

  function automatic void despeckle_predict(input in_item_t it);
    logic [LEVEL_W-1:0] lv;
    if (it.op == OP_FLUSH) begin
      if (waiting_cnt != 0) emit_oldest_pixel();
      return;
    end
    lv = (it.level > LEVEL_MAX) ? LEVEL_MAX : it.level;
    seen_pixels.push_back(lv);
    if (seen_pixels.size() > HIST_DEPTH) void'(seen_pixels.pop_front());
    waiting_cnt++;
    if (waiting_cnt > dim_used(cols_reg, DEF_MAX_COLS)) emit_oldest_pixel();
  endfunction

  // Mostly short gaps, a few long ones, none at all in steady stretches.
  function automatic int unsigned idle_len(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LEVEL_W-1:0] textured_level(input int unsigned base);
    int unsigned r;
    int          lv;
    r = $urandom_range(0, 99);
    if (r < 6) return LEVEL_W'($urandom_range(10, 15));
    if (r < 22) return LEVEL_W'($urandom_range(0, 9));
    lv = int'(base) + int'($urandom_range(0, 2)) - 1;
    if (lv < 0) lv = 0;
    if (lv > 9) lv = 9;
    return lv[LEVEL_W-1:0];
  endfunction

  function automatic void queue_item(input logic op, input logic [LEVEL_W-1:0] lv);
    in_item_t it;
    it.op    = op;
    it.level = lv;
    queued_items.push_back(it);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Input driver: one transaction per handshake, predicted on acceptance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        despeckle_predict(in_item_i);
        tx_holding = 1'b0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_items.size() != 0) begin
          in_item_i  <= queued_items.pop_front();
          in_valid_i <= 1'b1;
          tx_holding = 1'b1;
          if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
          tx_gap = idle_len(tx_steady);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus one long hold so the input backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && results_seen >= 60 && queued_items.size() >= 16) begin
      long_hold_done = 1'b1;
      rx_hold        = 150;
      out_ready_i    <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
      rx_hold = idle_len(rx_steady);
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        $error("result with no pixel due: level %0d", out_item_o.out_level);
        mismatches++;
      end else begin
        exp_item = expected_pixels.pop_front();
        check_field("out_level", 32'(exp_item.out_level), 32'(out_item_o.out_level));
        check_field("glyph", 32'(exp_item.glyph), 32'(out_item_o.glyph));
        check_field("row_end", 32'(exp_item.row_end), 32'(out_item_o.row_end));
        check_field("frame_end", 32'(exp_item.frame_end), 32'(out_item_o.frame_end));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FRAME_COLS) begin
      cols_reg = data;
      restart_stream();
    end else if (idx == CFG_FRAME_ROWS) begin
      rows_reg = data;
      restart_stream();
    end
  endtask

  // Hold until every queued item is taken and every result has arrived.
  task automatic wait_idle();
    while (queued_items.size() != 0 || tx_holding || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned small_items, n_pix, cols, base, pause_at, spin;
    logic [CFG_W-1:0] cols_val, rows_val;
    bit first_phase;
    restart_stream();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Clamped 2x2 frame: lone pixel, single neighbour on flush, saturation,
    // flush with nothing pending.
    write_reg(CFG_FRAME_COLS, '0);
    write_reg(CFG_FRAME_ROWS, 11'd1);
    queue_item(OP_PIXEL, 4'd7);
    queue_item(OP_FLUSH, 4'd15);
    queue_item(OP_PIXEL, 4'd15);
    queue_item(OP_PIXEL, 4'd0);
    queue_item(OP_FLUSH, 4'd0);
    queue_item(OP_FLUSH, 4'd0);
    queue_item(OP_FLUSH, 4'd9);
    wait_idle();

    // 3x3 speckle whose average rounds half up; a write to an unused
    // register index in the middle must leave the stream alone.
    write_reg(CFG_FRAME_COLS, 11'd3);
    write_reg(CFG_FRAME_ROWS, 11'd3);
    queue_item(OP_PIXEL, 4'd1);
    queue_item(OP_PIXEL, 4'd4);
    queue_item(OP_PIXEL, 4'd1);
    queue_item(OP_PIXEL, 4'd5);
    queue_item(OP_PIXEL, 4'd9);
    queue_item(OP_PIXEL, 4'd5);
    wait_idle();
    write_reg(CFG_IDX_W'($urandom_range(CFG_FRAME_ROWS + 1, 2 ** CFG_IDX_W - 1)),
              CFG_W'($urandom_range(0, 2047)));
    queue_item(OP_PIXEL, 4'd1);
    queue_item(OP_PIXEL, 4'd4);
    queue_item(OP_PIXEL, 4'd1);
    repeat (4) queue_item(OP_FLUSH, LEVEL_W'($urandom_range(0, 15)));
    wait_idle();

    // Widest frame: enough rows of data to reach the upper line store.
    write_reg(CFG_FRAME_COLS, 11'd2047);
    write_reg(CFG_FRAME_ROWS, CFG_W'($urandom_range(2, 3)));
    base = $urandom_range(0, 9);
    for (int unsigned i = 0; i < DEF_MAX_COLS + 16; i++)
      queue_item(OP_PIXEL, textured_level(base));
    repeat (24) queue_item(OP_FLUSH, LEVEL_W'($urandom_range(0, 15)));
    wait_idle();

    small_items = 0;
    first_phase = 1'b1;
    while (small_items < SMALL_BUDGET) begin
      if (first_phase || $urandom_range(0, 4) != 0) begin
        cols_val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2))
                                                : CFG_W'($urandom_range(2, 9));
        case ($urandom_range(0, 7))
          0:       rows_val = CFG_W'($urandom_range(0, 2));
          1:       rows_val = 11'd1024;
          2:       rows_val = ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd1025;
          default: rows_val = CFG_W'($urandom_range(2, 6));
        endcase
        if ($urandom_range(0, 1) != 0) begin
          write_reg(CFG_FRAME_COLS, cols_val);
          if (first_phase || $urandom_range(0, 3) != 0) write_reg(CFG_FRAME_ROWS, rows_val);
        end else begin
          write_reg(CFG_FRAME_ROWS, rows_val);
          if (first_phase || $urandom_range(0, 3) != 0) write_reg(CFG_FRAME_COLS, cols_val);
        end
        first_phase = 1'b0;
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_FRAME_ROWS + 1, 2 ** CFG_IDX_W - 1)),
                  CFG_W'($urandom_range(0, 2047)));

      cols     = dim_used(cols_reg, DEF_MAX_COLS);
      n_pix    = $urandom_range(1, 5 * cols + 8);
      pause_at = ($urandom_range(0, 7) == 0) ? n_pix / 2 : n_pix;
      base     = $urandom_range(0, 9);
      for (int unsigned i = 0; i < n_pix; i++) begin
        if (i == pause_at) wait_idle();
        if ($urandom_range(0, 19) == 0) base = $urandom_range(0, 9);
        if ($urandom_range(0, 29) == 0) queue_item(OP_FLUSH, LEVEL_W'($urandom_range(0, 15)));
        else queue_item(OP_PIXEL, textured_level(base));
      end
      small_items += n_pix;
      // drain the tail most of the time; otherwise leave it pending
      if ($urandom_range(0, 4) != 0) begin
        repeat (cols + 2) queue_item(OP_FLUSH, LEVEL_W'($urandom_range(0, 15)));
        small_items += cols + 2;
      end
      wait_idle();
    end

    spin = 0;
    while ((queued_items.size() != 0 || tx_holding || expected_pixels.size() != 0)
           && spin < 100000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never emitted", expected_pixels.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// File: four_neighbor_despeckle_filter.f
+incdir+rtl
rtl/fdf_pkg.sv
rtl/fdf_out_fifo.sv
rtl/four_neighbor_despeckle_filter.sv
tb/tb_four_neighbor_despeckle_filter.sv
